@@ src/erm_pkg.sv @@
// Shared types, constants and tables for the scheduling metric unit.
package erm_pkg;

	localparam int MAX_FLOWS_DEF  = 1024;
	localparam int FLOW_CAP_LIMIT = 2047;

	localparam int S_TDATA_W = 120;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = 1;
	localparam int BW_W      = 24;

	localparam int DIV_NW = 48;
	localparam int DIV_DW = 32;

	localparam logic [23:0] RB_BW_RESET = 24'd180000;
	localparam logic [23:0] M24         = 24'hFFFFFF;
	localparam logic [39:0] M40         = 40'hFF_FFFF_FFFF;
	localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
	localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
	localparam logic [29:0] LN2_Q30     = 30'd744261118;
	localparam logic [4:0]  ITER_LAST   = 5'd19;

	localparam logic [1:0] OP_ACC = 2'd0;
	localparam logic [1:0] OP_FIN = 2'd1;
	localparam logic [1:0] OP_MET = 2'd2;

	localparam logic [2:0] CLS_INF   = 3'd0;
	localparam logic [2:0] CLS_CBR   = 3'd1;
	localparam logic [2:0] CLS_TRACE = 3'd2;
	localparam logic [2:0] CLS_VOIP  = 3'd3;

	typedef enum logic [4:0] {
		DP_NOP, DP_LOAD, DP_LOG_INIT, DP_LOG_STEP, DP_L10, DP_WMUL, DP_WDIV, DP_WSTORE,
		DP_ACC, DP_FDIV, DP_FSTORE, DP_RMUL, DP_RDIV, DP_RSTORE, DP_PLAIN, DP_SQ_INIT,
		DP_SQ_STEP, DP_XDIV, DP_XSTORE, DP_YMUL, DP_TMUL, DP_E_MUL, DP_E_RECIP,
		DP_E_CORR, DP_M_MUL, DP_M_ADD, DP_M_FIN, DP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_LOG_INIT, ST_LOG, ST_L10, ST_WMUL, ST_WDIV, ST_WWAIT,
		ST_ACC, ST_FDIV, ST_FWAIT, ST_RMUL, ST_RDIV, ST_RWAIT, ST_PLAIN, ST_SQ_INIT,
		ST_SQ, ST_XDIV, ST_XWAIT, ST_YMUL, ST_TMUL, ST_E1, ST_E2, ST_E3, ST_MMUL,
		ST_MADD, ST_MFIN, ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [4:0] n;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       counted;
		logic       pf;
		logic       div_done;
	} dp_sts_t;

	// floor(2^32 / n) for the series terms
	function automatic logic [32:0] recip(input logic [4:0] n);
		logic [32:0] r;
		case (n)
			5'd1:    r = 33'd4294967296;
			5'd2:    r = 33'd2147483648;
			5'd3:    r = 33'd1431655765;
			5'd4:    r = 33'd1073741824;
			5'd5:    r = 33'd858993459;
			5'd6:    r = 33'd715827882;
			5'd7:    r = 33'd613566756;
			5'd8:    r = 33'd536870912;
			5'd9:    r = 33'd477218588;
			5'd10:   r = 33'd429496729;
			5'd11:   r = 33'd390451572;
			5'd12:   r = 33'd357913941;
			5'd13:   r = 33'd330382099;
			5'd14:   r = 33'd306783378;
			5'd15:   r = 33'd286331153;
			5'd16:   r = 33'd268435456;
			5'd17:   r = 33'd252645135;
			5'd18:   r = 33'd238609294;
			5'd19:   r = 33'd226050910;
			5'd20:   r = 33'd214748364;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ src/erm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module erm_div import erm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [DIV_DW:0]   rem_sh, diff;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/erm_dp.sv @@
// Datapath: input and state registers, log, sqrt, series and result arithmetic.
module erm_dp import erm_pkg::*; #(
	parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic                 cfg_we,
	input  logic [BW_W-1:0]      cfg_data,
	input  logic [S_TDATA_W-1:0] in_tdata,
	input  logic [S_TUSER_W-1:0] in_tuser,
	output logic [39:0]          metric,
	output logic                 metric_saturated,
	output logic [23:0]          average_weight,
	output logic [10:0]          flow_count
);

	localparam int FLOW_CAP = (MAX_FLOWS < FLOW_CAP_LIMIT) ? MAX_FLOWS : FLOW_CAP_LIMIT;

	logic [1:0]  op_q;
	logic [2:0]  cls_q;
	logic        hp_q;
	logic [15:0] dp_q, se_q;
	logic [23:0] maxd_q, hol_q, bw_q;
	logic [31:0] rate_q;
	logic [33:0] sum_q;
	logic [10:0] cnt_q;
	logic [23:0] avg_q;

	logic [30:0] lx_q;
	logic [3:0]  k_q;
	logic [19:0] frac_q;
	logic [23:0] nl10_q, w_q, xv_q;
	logic [47:0] num_q;
	logic [43:0] r_q;
	logic [39:0] sv_q;
	logic [19:0] root_q;
	logic [23:0] srem_q;
	logic [24:0] y_q;
	logic [29:0] t_q;
	logic [30:0] term_q, v_q, qe_q;
	logic [31:0] esum_q;
	logic [60:0] hi_q;
	logic [46:0] lo_q, m_q;
	logic [39:0] res_metric_q, out_metric_q;
	logic        res_sat_q, out_sat_q;
	logic [23:0] out_avg_q;
	logic [10:0] out_cnt_q;

	logic [15:0] in_dp;
	logic [23:0] in_maxd;
	logic [31:0] in_rate;
	logic [3:0]  k_w;
	logic [30:0] lx_init;
	logic [61:0] sq;
	logic [31:0] sq_hi;
	logic [24:0] nlog2;
	logic [55:0] l10_p;
	logic [23:0] sr_trial_base;
	logic [23:0] srem_sh, sr_trial;
	logic        sr_ge;
	logic [23:0] d_w;
	logic [20:0] sdiv;
	logic [54:0] y_p;
	logic [59:0] t_p;
	logic [61:0] e_p;
	logic [63:0] r_p;
	logic [35:0] nq, remv;
	logic [30:0] qc;
	logic [61:0] madd;
	logic [8:0]  ip;
	logic [39:0] lim;
	logic [34:0] s35;
	logic        div_start, div_done;
	logic [DIV_NW-1:0] div_a, div_q;
	logic [DIV_DW-1:0] div_b;

	assign in_dp   = in_tdata[16:1];
	assign in_maxd = in_tdata[40:17];
	assign in_rate = in_tdata[112:81];

	always_comb begin
		k_w = '0;
		for (int i = 0; i < 16; i++) begin
			if (dp_q[i]) k_w = 4'(i);
		end
	end

	// normalise the probability so that its leading one sits at bit 30
	assign lx_init = {15'b0, dp_q} << (5'd30 - {1'b0, k_w});
	assign sq      = 62'(lx_q) * 62'(lx_q);
	assign sq_hi   = sq[61:30];
	assign nlog2   = 25'h1000000 - {1'b0, k_q, frac_q};
	assign l10_p   = 56'(nlog2) * 56'(LOG10_2_Q32);

	assign srem_sh       = {srem_q[21:0], sv_q[39:38]};
	assign sr_trial_base = {2'b0, root_q, 2'b01};
	assign sr_trial      = sr_trial_base;
	assign sr_ge         = srem_sh >= sr_trial;

	assign d_w  = (w_q > avg_q) ? w_q - avg_q : '0;
	assign sdiv = 21'h10000 + {1'b0, root_q};
	assign y_p  = 55'(xv_q) * 55'(LOG2E_Q30);
	assign t_p  = 60'({y_q[15:0], 14'b0}) * 60'(LN2_Q30);
	assign e_p  = 62'(term_q) * 62'(t_q);
	assign r_p  = 64'(v_q) * 64'(recip(cmd.n));
	assign nq   = 36'(qe_q) * 36'(cmd.n);
	assign remv = 36'(v_q) - nq;
	// the reciprocal estimate is at most one short
	assign qc   = (remv >= 36'(cmd.n)) ? qe_q + 31'd1 : qe_q;
	assign madd = 62'(hi_q) + 62'(lo_q[46:15]);
	assign ip   = y_q[24:16];
	assign lim  = M40 >> ip[5:0];
	assign s35  = 35'(sum_q) + 35'(w_q);

	always_comb begin
		div_start = 1'b1;
		div_a     = num_q;
		div_b     = 32'(maxd_q);
		case (cmd.op)
			DP_WDIV: begin
				div_a = num_q;
				div_b = 32'(maxd_q);
			end
			DP_FDIV: begin
				div_a = 48'(sum_q);
				div_b = 32'(cnt_q);
			end
			DP_RDIV: begin
				div_a = num_q;
				div_b = rate_q;
			end
			DP_XDIV: begin
				div_a = {8'b0, d_w, 16'b0};
				div_b = 32'(sdiv);
			end
			default: div_start = 1'b0;
		endcase
	end

	erm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		sts.op       = op_q;
		sts.counted  = hp_q && (cls_q == CLS_TRACE || cls_q == CLS_VOIP) &&
			(cnt_q < 11'(FLOW_CAP));
		sts.pf       = (cls_q == CLS_INF) || (cls_q == CLS_CBR);
		sts.div_done = div_done;
	end

	// round state and bandwidth register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= RB_BW_RESET;
			sum_q <= '0;
			cnt_q <= '0;
			avg_q <= '0;
		end else begin
			if (cfg_we) bw_q <= cfg_data;
			case (cmd.op)
				DP_ACC: begin
					sum_q <= s35[34] ? '1 : s35[33:0];
					cnt_q <= cnt_q + 11'd1;
				end
				DP_FSTORE: begin
					avg_q <= (cnt_q != '0) ? div_q[23:0] : '0;
					sum_q <= '0;
					cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q         <= in_tuser[1:0];
				cls_q        <= in_tuser[4:2];
				hp_q         <= in_tdata[0];
				dp_q         <= (in_dp == '0) ? 16'd1 : in_dp;
				maxd_q       <= (in_maxd == '0) ? 24'd1 : in_maxd;
				hol_q        <= in_tdata[64:41];
				se_q         <= in_tdata[80:65];
				rate_q       <= (in_rate == '0) ? 32'd1 : in_rate;
				res_metric_q <= '0;
				res_sat_q    <= 1'b0;
			end
			DP_LOG_INIT: begin
				lx_q   <= lx_init;
				k_q    <= k_w;
				frac_q <= '0;
			end
			DP_LOG_STEP: begin
				lx_q   <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
				frac_q <= {frac_q[18:0], sq_hi[31]};
			end
			DP_L10:    nl10_q <= l10_p[55:32];
			DP_WMUL:   num_q  <= 48'(nl10_q) * 48'(hol_q);
			DP_WSTORE: w_q    <= (div_q[47:28] != '0) ? M24 : div_q[27:4];
			DP_RMUL:   num_q  <= {4'b0, 40'(se_q) * 40'(bw_q), 4'b0};
			DP_RSTORE: r_q    <= div_q[43:0];
			DP_PLAIN: begin
				res_metric_q <= (r_q[43:40] != '0) ? M40 : r_q[39:0];
				res_sat_q    <= (r_q[43:40] != '0);
			end
			DP_SQ_INIT: begin
				sv_q   <= {avg_q, 16'b0};
				root_q <= '0;
				srem_q <= '0;
			end
			DP_SQ_STEP: begin
				sv_q   <= {sv_q[37:0], 2'b0};
				srem_q <= sr_ge ? srem_sh - sr_trial : srem_sh;
				root_q <= {root_q[18:0], sr_ge};
			end
			DP_XSTORE: xv_q <= div_q[23:0];
			DP_YMUL:   y_q  <= y_p[54:30];
			DP_TMUL: begin
				t_q    <= t_p[59:30];
				term_q <= 31'h40000000;
				esum_q <= 32'h40000000;
			end
			DP_E_MUL:   v_q  <= e_p[60:30];
			DP_E_RECIP: qe_q <= r_p[62:32];
			DP_E_CORR: begin
				term_q <= qc;
				esum_q <= esum_q + 32'(qc);
			end
			DP_M_MUL: begin
				hi_q <= 61'(r_q[43:15]) * 61'(esum_q);
				lo_q <= 47'(r_q[14:0]) * 47'(esum_q);
			end
			DP_M_ADD: m_q <= madd[61:15];
			DP_M_FIN: begin
				if (m_q == '0) begin
					res_metric_q <= '0;
					res_sat_q    <= 1'b0;
				end else if (ip >= 9'd40 || m_q > 47'(lim)) begin
					res_metric_q <= M40;
					res_sat_q    <= 1'b1;
				end else begin
					res_metric_q <= m_q[39:0] << ip[5:0];
					res_sat_q    <= 1'b0;
				end
			end
			DP_OUT: begin
				out_metric_q <= res_metric_q;
				out_sat_q    <= res_sat_q;
				out_avg_q    <= avg_q;
				out_cnt_q    <= cnt_q;
			end
			default: ;
		endcase
	end

	assign metric           = out_metric_q;
	assign metric_saturated = out_sat_q;
	assign average_weight   = out_avg_q;
	assign flow_count       = out_cnt_q;

endmodule

@@ src/erm_ctrl.sv @@
// Controller: sequences the datapath and owns both stream handshakes.
module erm_ctrl import erm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic [4:0]  iter_q;
	logic        ovalid_q;
	logic        out_free;

	assign out_free = !ovalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_DECODE;
			ST_DECODE: begin
				case (sts.op)
					OP_ACC:  state_d = sts.counted ? ST_LOG_INIT : ST_DONE;
					OP_FIN:  state_d = ST_FDIV;
					OP_MET:  state_d = ST_RMUL;
					default: state_d = ST_DONE;
				endcase
			end
			ST_LOG_INIT: state_d = ST_LOG;
			ST_LOG:      if (iter_q == ITER_LAST) state_d = ST_L10;
			ST_L10:      state_d = ST_WMUL;
			ST_WMUL:     state_d = ST_WDIV;
			ST_WDIV:     state_d = ST_WWAIT;
			ST_WWAIT:    if (sts.div_done) state_d = (sts.op == OP_ACC) ? ST_ACC : ST_SQ_INIT;
			ST_ACC:      state_d = ST_DONE;
			ST_FDIV:     state_d = ST_FWAIT;
			ST_FWAIT:    if (sts.div_done) state_d = ST_DONE;
			ST_RMUL:     state_d = ST_RDIV;
			ST_RDIV:     state_d = ST_RWAIT;
			ST_RWAIT:    if (sts.div_done) state_d = sts.pf ? ST_PLAIN : ST_LOG_INIT;
			ST_PLAIN:    state_d = ST_DONE;
			ST_SQ_INIT:  state_d = ST_SQ;
			ST_SQ:       if (iter_q == ITER_LAST) state_d = ST_XDIV;
			ST_XDIV:     state_d = ST_XWAIT;
			ST_XWAIT:    if (sts.div_done) state_d = ST_YMUL;
			ST_YMUL:     state_d = ST_TMUL;
			ST_TMUL:     state_d = ST_E1;
			ST_E1:       state_d = ST_E2;
			ST_E2:       state_d = ST_E3;
			ST_E3:       state_d = (iter_q == ITER_LAST) ? ST_MMUL : ST_E1;
			ST_MMUL:     state_d = ST_MADD;
			ST_MADD:     state_d = ST_MFIN;
			ST_MFIN:     state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.n  = iter_q + 5'd1;
		cmd.op = DP_NOP;
		case (state_q)
			ST_IDLE:     if (s_tvalid) cmd.op = DP_LOAD;
			ST_LOG_INIT: cmd.op = DP_LOG_INIT;
			ST_LOG:      cmd.op = DP_LOG_STEP;
			ST_L10:      cmd.op = DP_L10;
			ST_WMUL:     cmd.op = DP_WMUL;
			ST_WDIV:     cmd.op = DP_WDIV;
			ST_WWAIT:    if (sts.div_done) cmd.op = DP_WSTORE;
			ST_ACC:      cmd.op = DP_ACC;
			ST_FDIV:     cmd.op = DP_FDIV;
			ST_FWAIT:    if (sts.div_done) cmd.op = DP_FSTORE;
			ST_RMUL:     cmd.op = DP_RMUL;
			ST_RDIV:     cmd.op = DP_RDIV;
			ST_RWAIT:    if (sts.div_done) cmd.op = DP_RSTORE;
			ST_PLAIN:    cmd.op = DP_PLAIN;
			ST_SQ_INIT:  cmd.op = DP_SQ_INIT;
			ST_SQ:       cmd.op = DP_SQ_STEP;
			ST_XDIV:     cmd.op = DP_XDIV;
			ST_XWAIT:    if (sts.div_done) cmd.op = DP_XSTORE;
			ST_YMUL:     cmd.op = DP_YMUL;
			ST_TMUL:     cmd.op = DP_TMUL;
			ST_E1:       cmd.op = DP_E_MUL;
			ST_E2:       cmd.op = DP_E_RECIP;
			ST_E3:       cmd.op = DP_E_CORR;
			ST_MMUL:     cmd.op = DP_M_MUL;
			ST_MADD:     cmd.op = DP_M_ADD;
			ST_MFIN:     cmd.op = DP_M_FIN;
			ST_DONE:     if (out_free) cmd.op = DP_OUT;
			default:     cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			iter_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOG_INIT, ST_SQ_INIT, ST_TMUL: iter_q <= '0;
				ST_LOG, ST_SQ, ST_E3:             iter_q <= iter_q + 5'd1;
				default: ;
			endcase
			// hold the result until the downstream transaction completes
			if (state_q == ST_DONE && out_free) ovalid_q <= 1'b1;
			else if (m_tready)                  ovalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;

endmodule

@@ src/exp_rule_scheduling_metric.sv @@
// EXP/PF scheduling metric unit, top level.
// One item is processed at a time; the next is taken once its result sits in the output register.
// Work depends on the item: the shared 48-step divider serves counted accumulates, finalize and
// all metrics; the 20-round log loop serves counted accumulates and exponential-rule metrics,
// which also run the 20-round sqrt loop and the 20-term series.
// Reset clears control, weight sum, flow count and average weight; bandwidth returns to 180000.
module exp_rule_scheduling_metric import erm_pkg::*; #(
	parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// has_packets, drop_probability, max_delay_us, hol_delay_us, spectral_efficiency,
	// average_rate_bps
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation, app_class
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// metric, average_weight, flow_count
	output logic [M_TDATA_W-1:0] m_tdata,
	// metric_saturated
	output logic [M_TUSER_W-1:0] m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [BW_W-1:0]      cfg_data
);

	localparam int FLOW_CAP = (MAX_FLOWS < FLOW_CAP_LIMIT) ? MAX_FLOWS : FLOW_CAP_LIMIT;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [39:0] metric;
	logic        metric_saturated;
	logic [23:0] average_weight;
	logic [10:0] flow_count;

	assign cfg_ready = 1'b1;

	erm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	erm_dp #(.MAX_FLOWS(MAX_FLOWS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_valid),
		.cfg_data         (cfg_data),
		.in_tdata         (s_tdata),
		.in_tuser         (s_tuser),
		.metric           (metric),
		.metric_saturated (metric_saturated),
		.average_weight   (average_weight),
		.flow_count       (flow_count)
	);

	assign m_tdata = {5'b0, flow_count, average_weight, metric};
	assign m_tuser = metric_saturated;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again before the result was produced");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[74:64] <= 11'(FLOW_CAP)))
		else $error("flow count beyond the round limit");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[39:0] == M40))
		else $error("saturated metric not clamped");

endmodule

@@ test/exp_rule_scheduling_metric_tb.sv @@
// Self-checking testbench for the EXP/PF scheduling metric unit.
`timescale 1ns / 100ps

module exp_rule_scheduling_metric_tb;
	import erm_pkg::*;

	localparam logic [1:0] OP_NONE   = 2'd3;
	localparam logic [2:0] CLS_OTHER = 3'd4;
	localparam int         CYCLE_LIMIT = 3000000;
	localparam int         FLOW_CAP = (MAX_FLOWS_DEF < FLOW_CAP_LIMIT) ? MAX_FLOWS_DEF
		: FLOW_CAP_LIMIT;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  cls;
		logic        hasp;
		logic [15:0] dp;
		logic [23:0] maxd;
		logic [23:0] hol;
		logic [15:0] se;
		logic [31:0] rate;
	} flow_item_t;

	typedef struct {
		logic [39:0] metric;
		logic        sat;
		logic [23:0] avg;
		logic [10:0] cnt;
	} metric_res_t;

	class metric_scoreboard;
		bit [63:0]   bandwidth;
		bit [63:0]   weight_sum;
		bit [63:0]   flows;
		bit [63:0]   avg_w;
		metric_res_t pending[$];
		int          fails;

		function new();
			bandwidth  = 180000;
			weight_sum = 0;
			flows      = 0;
			avg_w      = 0;
			fails      = 0;
		endfunction

		function bit [63:0] delay_weight(bit [63:0] dp, bit [63:0] maxd, bit [63:0] hol);
			bit [63:0] k, x, frac, nl2, nl10, w;
			k    = 0;
			frac = 0;
			if (dp == 0) dp = 1;
			if (maxd == 0) maxd = 1;
			while (k < 15 && (dp >> (k + 1)) != 0) k++;
			x = dp << (30 - k);
			for (int i = 0; i < 20; i++) begin
				x = (x * x) >> 30;
				frac = frac << 1;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					frac = frac | 1;
				end
			end
			nl2  = (64'd16 << 20) - ((k << 20) | frac);
			nl10 = (nl2 * 64'd1292913986) >> 32;
			w    = ((nl10 * hol) / maxd) >> 4;
			return (w > 64'hFFFFFF) ? 64'hFFFFFF : w;
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function bit [63:0] pow2_frac(bit [63:0] f);
			bit [63:0] t, sum, term;
			t    = ((f << 14) * 64'd744261118) >> 30;
			sum  = 64'd1 << 30;
			term = sum;
			for (int n = 1; n <= 20; n++) begin
				term = ((term * t) >> 30) / n;
				sum  = sum + term;
			end
			return sum;
		endfunction

		// Predict the result of one accepted transaction and queue it
		function void note_item(flow_item_t it);
			metric_res_t e;
			bit [63:0] r, w, d, s, x, y, ip, p, hi, lo, m, rate, met;
			met = 0;
			e.sat = 0;
			if (it.op == OP_ACC) begin
				if (it.hasp && (it.cls == CLS_TRACE || it.cls == CLS_VOIP) && flows < FLOW_CAP)
						begin
					s = weight_sum + delay_weight(64'(it.dp), 64'(it.maxd), 64'(it.hol));
					weight_sum = (s > 64'h3FFFFFFFF) ? 64'h3FFFFFFFF : s;
					flows++;
				end
			end else if (it.op == OP_FIN) begin
				avg_w = flows ? ((weight_sum / flows) & 64'hFFFFFF) : 0;
				weight_sum = 0;
				flows = 0;
			end else if (it.op == OP_MET) begin
				rate = 64'(it.rate);
				if (rate == 0) rate = 1;
				r = ((64'(it.se) * bandwidth) << 4) / rate;
				if (it.cls == CLS_INF || it.cls == CLS_CBR) begin
					met = r;
				end else begin
					w  = delay_weight(64'(it.dp), 64'(it.maxd), 64'(it.hol));
					d  = (w > avg_w) ? w - avg_w : 0;
					s  = int_sqrt(avg_w << 16);
					x  = (d << 16) / ((64'd1 << 16) + s);
					y  = (x * 64'd1549082005) >> 30;
					ip = y >> 16;
					p  = pow2_frac(y & 64'hFFFF);
					hi = (r >> 15) * p;
					lo = (r & 64'h7FFF) * p;
					m  = (hi + (lo >> 15)) >> 15;
					if (m == 0) met = 0;
					else if (ip >= 40 || m > (64'hFFFFFFFFFF >> ip)) met = 64'h10000000000;
					else met = m << ip;
				end
				if (met > 64'hFFFFFFFFFF) begin
					met = 64'hFFFFFFFFFF;
					e.sat = 1;
				end
			end
			e.metric = met[39:0];
			e.avg    = avg_w[23:0];
			e.cnt    = flows[10:0];
			pending.push_back(e);
		endfunction

		function void check_result(metric_res_t a);
			metric_res_t e;
			if (pending.size() == 0) begin
				$error("result with no prediction waiting");
				fails++;
				return;
			end
			e = pending.pop_front();
			if (a.metric !== e.metric) begin
				$error("metric: expected %0d, actual %0d", e.metric, a.metric);
				fails++;
			end
			if (a.sat !== e.sat) begin
				$error("metric_saturated: expected %0d, actual %0d", e.sat, a.sat);
				fails++;
			end
			if (a.avg !== e.avg) begin
				$error("average_weight: expected %0d, actual %0d", e.avg, a.avg);
				fails++;
			end
			if (a.cnt !== e.cnt) begin
				$error("flow_count: expected %0d, actual %0d", e.cnt, a.cnt);
				fails++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [BW_W-1:0]      cfg_data;

	metric_scoreboard sb;
	bit  calm;
	bit  hold_req;
	int  cycles;
	int  sent;

	exp_rule_scheduling_metric DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold on request
	initial begin
		int hold;
		hold = 0;
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold = 400;
				hold_req = 0;
			end
			if (hold > 0) begin
				m_tready <= 0;
				hold--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		metric_res_t a;
		if (arst_n && m_tvalid && m_tready) begin
			a.metric = m_tdata[39:0];
			a.avg    = m_tdata[63:40];
			a.cnt    = m_tdata[74:64];
			a.sat    = m_tuser[0];
			sb.check_result(a);
		end
	end

	task automatic send(flow_item_t it);
		s_tdata  <= {7'd0, it.rate, it.se, it.hol, it.maxd, it.dp, it.hasp};
		s_tuser  <= {it.cls, it.op};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(it);
		sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_bandwidth(logic [23:0] v);
		drain();
		cfg_data  <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.bandwidth = 64'(v);
	endtask

	function automatic flow_item_t make_item(logic [1:0] op, logic [2:0] cls);
		flow_item_t it;
		it.op   = op;
		it.cls  = cls;
		it.hasp = ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 3))
			0: it.dp = 16'd1;
			1: it.dp = 16'hFFFF;
			2: it.dp = 16'($urandom_range(1, 16));
			default: it.dp = 16'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(0, 3))
			0: it.maxd = 24'hFFFFFF;
			1: it.maxd = 24'($urandom_range(1, 1000));
			default: it.maxd = 24'($urandom_range(1, 24'hFFFFFF));
		endcase
		if ($urandom_range(0, 1)) it.hol = 24'($urandom_range(0, 24'hFFFFFF));
		else it.hol = 24'($urandom_range(0, it.maxd));
		it.se = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 2) == 0) it.rate = 32'($urandom_range(1, 1000));
		else it.rate = $urandom;
		if (it.rate == 0) it.rate = 1;
		return it;
	endfunction

	function automatic flow_item_t fixed_item(logic [1:0] op, logic [2:0] cls, logic hasp,
			logic [15:0] dp, logic [23:0] maxd, logic [23:0] hol, logic [15:0] se,
			logic [31:0] rate);
		flow_item_t it;
		it.op = op;  it.cls = cls;   it.hasp = hasp; it.dp = dp;
		it.maxd = maxd; it.hol = hol; it.se = se;    it.rate = rate;
		return it;
	endfunction

	// One scheduling round: accumulate flows, finalize (in most rounds), then metrics with an occasional unused code
	task automatic random_round();
		flow_item_t it;
		int n;
		n = $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			it = make_item(OP_ACC, 3'($urandom_range(0, 9) < 8 ? $urandom_range(2, 3)
				: $urandom_range(0, 7)));
			send(it);
		end
		if ($urandom_range(0, 9) != 0) send(make_item(OP_FIN, 3'($urandom_range(0, 7))));
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0) send(make_item(OP_NONE, 3'($urandom_range(0, 7))));
			else send(make_item(OP_MET, 3'($urandom_range(0, 7))));
		end
	endtask

	initial begin
		logic [23:0] bws[5];
		clk       = 0;
		arst_n    = 0;
		s_tvalid  = 0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 0;
		cfg_data  = '0;
		calm      = 0;
		hold_req  = 0;
		cycles    = 0;
		sent      = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty finalize, unused code, uncounted and counted flows, extremes
		send(fixed_item(OP_FIN, CLS_TRACE, 1, 16'd1, 24'd1, 24'd0, 16'd0, 32'd1));
		send(fixed_item(OP_NONE, CLS_VOIP, 1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF,
			32'hFFFFFFFF));
		send(fixed_item(OP_ACC, CLS_TRACE, 0, 16'd1, 24'd1, 24'hFFFFFF, 16'd0, 32'd1));
		send(fixed_item(OP_ACC, CLS_INF, 1, 16'd1, 24'd1, 24'hFFFFFF, 16'd0, 32'd1));
		send(fixed_item(OP_ACC, CLS_OTHER, 1, 16'd1, 24'd1, 24'hFFFFFF, 16'd0, 32'd1));
		send(fixed_item(OP_ACC, CLS_TRACE, 1, 16'd1, 24'd1, 24'hFFFFFF, 16'd0, 32'd1));
		send(fixed_item(OP_ACC, CLS_VOIP, 1, 16'hFFFF, 24'hFFFFFF, 24'd0, 16'd0, 32'd1));
		send(fixed_item(OP_ACC, CLS_VOIP, 1, 16'd655, 24'd100000, 24'd40000, 16'd0, 32'd1));
		send(fixed_item(OP_FIN, CLS_INF, 0, 16'd1, 24'd1, 24'd0, 16'd0, 32'd1));
		send(fixed_item(OP_MET, CLS_INF, 0, 16'd1, 24'd1, 24'd0, 16'hFFFF, 32'd1));
		send(fixed_item(OP_MET, CLS_CBR, 0, 16'd1, 24'd1, 24'd0, 16'd0, 32'hFFFFFFFF));
		send(fixed_item(OP_MET, CLS_TRACE, 1, 16'd1, 24'd1, 24'hFFFFFF, 16'hFFFF, 32'd1));
		send(fixed_item(OP_MET, CLS_VOIP, 1, 16'd655, 24'd100000, 24'd90000, 16'd8192,
			32'd500000));
		send(fixed_item(OP_MET, CLS_OTHER, 1, 16'hFFFF, 24'hFFFFFF, 24'd0, 16'd4096,
			32'd1000));
		send(fixed_item(OP_MET, 3'd5, 1, 16'd100, 24'd1000, 24'd2000, 16'd4096, 32'd100000));
		send(fixed_item(OP_MET, 3'd7, 1, 16'd1, 24'd1000, 24'd999, 16'hFFFF, 32'hFFFFFFFF));
		send(fixed_item(OP_NONE, CLS_INF, 0, 16'd1, 24'd1, 24'd0, 16'd0, 32'd1));

		bws[0] = 24'd1;
		bws[1] = 24'hFFFFFF;
		bws[2] = 24'($urandom_range(1, 24'hFFFFFF));
		bws[3] = RB_BW_RESET;
		bws[4] = 24'($urandom_range(1, 24'hFFFFFF));
		for (int ph = 0; ph < 5; ph++) begin
			write_bandwidth(bws[ph]);
			// PF metric with the largest spectral efficiency and lowest rate; it saturates at the top bandwidth
			send(fixed_item(OP_MET, CLS_INF, 0, 16'd1, 24'd1, 24'd0, 16'hFFFF, 32'd1));
			// Long receiver hold while items keep coming
			if (ph == 1) hold_req = 1;
			if (ph == 4) calm = 1;
			while (sent < 17 + (ph + 1) * 160) begin
				random_round();
			end
		end

		drain();
		if (sb.fails == 0 && sb.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ exp_rule_scheduling_metric.f @@
src/erm_pkg.sv
src/erm_div.sv
src/erm_dp.sv
src/erm_ctrl.sv
src/exp_rule_scheduling_metric.sv
test/exp_rule_scheduling_metric_tb.sv
